@@ rtl/core/uart_frame_checker_macros.svh @@
// Assertion macros used by the frame checker parser.
`ifndef UART_FRAME_CHECKER_MACROS_SVH
`define UART_FRAME_CHECKER_MACROS_SVH
`ifndef SYNTHESIS
`define UFC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("frame checker assertion failed");
`define UFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame checker assertion failed");
`else
`define UFC_ASSERT(lbl, clk, rst_n, prop)
`define UFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/ufc_pkg.sv @@
package ufc_pkg;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_BODY,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_PHOTO     = 3'd0,
    ST_READY     = 3'd1,
    ST_NOT_READY = 3'd2,
    ST_NO_HEADER = 3'd3,
    ST_TRUNCATED = 3'd4,
    ST_CHECKSUM  = 3'd5,
    ST_INVALID   = 3'd6
  } status_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } result_t;

  localparam logic [7:0] HDR_0     = 8'h24;
  localparam logic [7:0] HDR_1     = 8'h46;
  localparam logic [7:0] HDR_2     = 8'h47;
  localparam logic [1:0] HDR_LAST  = 2'd2;
  localparam logic [7:0] TYPE_PHOTO = 8'h26;
  localparam logic [7:0] TYPE_HS    = 8'h48;

  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd1:    b = HDR_1;
      2'd2:    b = HDR_2;
      default: b = HDR_0;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/core/ufc_parser.sv @@
`include "uart_frame_checker_macros.svh"

module ufc_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  logic             end_of_buffer,
  input  logic [7:0]       ready_code,
  output ufc_pkg::result_t result
);
  import ufc_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [1:0] matched_r, matched_nxt;
  logic [8:0] offset_r, offset_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] type_r, type_nxt;
  logic [7:0] data2_r, data2_nxt;
  logic [7:0] len_eff;
  status_t    status;

  always_comb begin
    phase_nxt   = phase_r;
    matched_nxt = matched_r;
    offset_nxt  = offset_r;
    len_nxt     = len_r;
    sum_nxt     = sum_r;
    type_nxt    = type_r;
    data2_nxt   = data2_r;
    len_eff     = (offset_r == 9'd0) ? rx_byte : len_r;
    if (step) begin
      case (phase_r)
        PH_HUNT: begin
          if (rx_byte == hdr_byte(matched_r)) begin
            if (matched_r == HDR_LAST) begin
              phase_nxt   = PH_BODY;
              matched_nxt = 2'd0;
              offset_nxt  = 9'd0;
            end else begin
              matched_nxt = matched_r + 2'd1;
            end
          end else begin
            matched_nxt = (rx_byte == HDR_0) ? 2'd1 : 2'd0;
          end
        end
        PH_BODY: begin
          len_nxt = len_eff;
          if (offset_r == 9'd1) begin
            type_nxt = rx_byte;
          end
          if (offset_r == 9'd2) begin
            data2_nxt = rx_byte;
          end
          if (offset_r < {1'b0, len_eff}) begin
            sum_nxt = sum_r + rx_byte;
          end else if (offset_r == {1'b0, len_eff}) begin
            sum_nxt = sum_r ^ rx_byte;
          end
          if (offset_r == {1'b0, len_eff} + 9'd1) begin
            phase_nxt = PH_DONE;
          end else begin
            offset_nxt = offset_r + 9'd1;
          end
        end
        default: ;
      endcase
    end

    if (phase_nxt == PH_HUNT) begin
      status = ST_NO_HEADER;
    end else if (phase_nxt != PH_DONE) begin
      status = ST_TRUNCATED;
    end else if (sum_nxt != 8'd0) begin
      status = ST_CHECKSUM;
    end else if (type_nxt == TYPE_PHOTO) begin
      status = ST_PHOTO;
    end else if (type_nxt == TYPE_HS) begin
      status = (data2_nxt == ready_code) ? ST_READY : ST_NOT_READY;
    end else begin
      status = ST_INVALID;
    end

    result.valid  = step && end_of_buffer;
    result.status = status;

    if (step && end_of_buffer) begin
      phase_nxt   = PH_HUNT;
      matched_nxt = 2'd0;
      offset_nxt  = 9'd0;
      len_nxt     = 8'd0;
      sum_nxt     = 8'd0;
      type_nxt    = 8'd0;
      data2_nxt   = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      matched_r <= 2'd0;
      offset_r  <= 9'd0;
      len_r     <= 8'd0;
      sum_r     <= 8'd0;
      type_r    <= 8'd0;
      data2_r   <= 8'd0;
    end else begin
      phase_r   <= phase_nxt;
      matched_r <= matched_nxt;
      offset_r  <= offset_nxt;
      len_r     <= len_nxt;
      sum_r     <= sum_nxt;
      type_r    <= type_nxt;
      data2_r   <= data2_nxt;
    end
  end

  `UFC_ASSERT(a_hunt_offset_zero, clk, rst_n, (phase_r != PH_HUNT) || (offset_r == 9'd0))
  `UFC_ASSERT(a_body_no_partial_hdr, clk, rst_n, (phase_r == PH_HUNT) || (matched_r == 2'd0))
  `UFC_ASSERT(a_offset_in_range, clk, rst_n, (offset_r <= ({1'b0, len_r} + 9'd1)))
  `UFC_ASSERT_NEXT(a_last_clears, clk, rst_n, step && end_of_buffer,
                   (phase_r == PH_HUNT) && (sum_r == 8'd0))

endmodule

@@ rtl/core/ufc_out_reg.sv @@
module ufc_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  ufc_pkg::result_t result,
  output logic             can_load,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata
);
  import ufc_pkg::*;

  logic    valid_r, valid_nxt;
  status_t status_r;

  assign can_load = !valid_r || out_tready;

  always_comb begin
    if (result.valid) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      status_r <= result.status;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {5'd0, status_r};

endmodule

@@ rtl/core/uart_frame_checker.sv @@
// Checks received UART buffers one byte per beat, in_tlast marking each buffer's final byte,
// and returns one status beat per buffer: photo request, ready, not ready, no header,
// truncated, checksum error or invalid type. A byte beat is accepted every cycle while the
// status output keeps draining; the status beat is offered after its final byte is accepted,
// has sat in the input register and has had its status land in the result register.
// The input stalls only when a final byte waits in the input register and the held status
// has not been taken. cfg_wr_data sets the ready code and should be written only while no
// buffer is in flight.
module uart_frame_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       in_tlast,   // end_of_buffer
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [2:0] frame_status, [7:3] zero
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import ufc_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic [7:0] ready_code_r;
  logic       can_load;
  logic       step;
  result_t    result;

  assign step      = in_valid_r && (!in_last_r || can_load);
  assign in_tready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      ready_code_r <= 8'd0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (cfg_wr_en) begin
        ready_code_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  ufc_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .rx_byte       (in_byte_r),
    .end_of_buffer (in_last_r),
    .ready_code    (ready_code_r),
    .result        (result)
  );

  ufc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .result     (result),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ sim/uart_frame_checker_tb.sv @@
`timescale 1ns / 100ps

module uart_frame_checker_tb;
  import ufc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rx_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] rx_byte
  logic       in_tlast = 1'b0;    // end_of_buffer
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [2:0] frame_status, [7:3] zero
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;

  rx_beat_t   pending_beats[$];
  logic [7:0] lead_bytes[$];
  status_t    expected_status_q[$];

  phase_t     frame_phase = PH_HUNT;
  logic [1:0] hdr_matched = 2'd0;
  logic [8:0] byte_offset = 9'd0;
  logic [7:0] frame_length = 8'd0;
  logic [7:0] running_sum = 8'd0;
  logic [7:0] type_byte = 8'd0;
  logic [7:0] data_byte2 = 8'd0;
  logic [7:0] ready_code_model = 8'd0;

  int beats_queued = 0;
  int beats_accepted = 0;
  int statuses_checked = 0;
  int error_count = 0;
  int status_count [0:6] = '{default: 0};
  int burst_left = 1;
  int gap_left = 0;
  int cycle_count = 0;
  int idle_cycles = 0;

  uart_frame_checker i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic status_t frame_verdict();
    if (frame_phase == PH_HUNT) return ST_NO_HEADER;
    if (frame_phase != PH_DONE) return ST_TRUNCATED;
    if (running_sum != 8'd0) return ST_CHECKSUM;
    if (type_byte == TYPE_PHOTO) return ST_PHOTO;
    if (type_byte == TYPE_HS) return (data_byte2 == ready_code_model) ? ST_READY : ST_NOT_READY;
    return ST_INVALID;
  endfunction

  task automatic track_frame_byte(input logic [7:0] b, input logic last);
    logic [7:0] want;
    logic [8:0] k;
    logic [8:0] n;
    if (frame_phase == PH_HUNT) begin
      case (hdr_matched)
        2'd0: want = HDR_0;
        2'd1: want = HDR_1;
        default: want = HDR_2;
      endcase
      if (b == want) begin
        if (hdr_matched == HDR_LAST) begin
          frame_phase = PH_BODY;
          hdr_matched = 2'd0;
          byte_offset = 9'd0;
        end else begin
          hdr_matched = hdr_matched + 2'd1;
        end
      end else begin
        hdr_matched = (b == HDR_0) ? 2'd1 : 2'd0;
      end
    end else if (frame_phase == PH_BODY) begin
      k = byte_offset;
      if (k == 9'd0) frame_length = b;
      n = {1'b0, frame_length};
      if (k == 9'd1) type_byte = b;
      if (k == 9'd2) data_byte2 = b;
      if (k < n) running_sum = running_sum + b;
      else if (k == n) running_sum = running_sum ^ b;
      if (k == n + 9'd1) frame_phase = PH_DONE;
      else byte_offset = k + 9'd1;
    end
    if (last) begin
      expected_status_q.push_back(frame_verdict());
      frame_phase = PH_HUNT;
      hdr_matched = 2'd0;
      byte_offset = 9'd0;
      frame_length = 8'd0;
      running_sum = 8'd0;
      type_byte = 8'd0;
      data_byte2 = 8'd0;
    end
  endtask

  function automatic logic [7:0] junk_byte();
    case ($urandom_range(0, 3))
      0: return HDR_0;
      1: return HDR_1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Builds one buffer: lead bytes, junk, header, length, body, checksum, the closing
  // byte and a tail of late bytes. A keep count of zero or more trims it to that many bytes, never below one.
  task automatic queue_buffer(input int n, input logic [7:0] kind, input logic [7:0] d2,
                              input logic [7:0] sum_err, input int junk, input int keep,
                              input int tail);
    logic [7:0] frame_q[$];
    logic [7:0] body [0:257];
    logic [7:0] sum;
    rx_beat_t beat;
    while (lead_bytes.size() > 0) frame_q.push_back(lead_bytes.pop_front());
    for (int i = 0; i < junk; i++) frame_q.push_back(junk_byte());
    frame_q.push_back(HDR_0);
    frame_q.push_back(HDR_1);
    frame_q.push_back(HDR_2);
    for (int i = 0; i < n + 2; i++) body[i] = 8'($urandom_range(0, 255));
    body[0] = 8'(n);
    body[1] = kind;
    if (n >= 1) begin
      body[2] = d2;
      sum = 8'd0;
      for (int i = 0; i < n; i++) sum = sum + body[i];
      body[n] = sum ^ sum_err;
    end
    for (int i = 0; i < n + 2; i++) frame_q.push_back(body[i]);
    for (int i = 0; i < tail; i++) frame_q.push_back(8'($urandom_range(0, 255)));
    if (keep >= 0) begin
      while (frame_q.size() > keep && frame_q.size() > 1) void'(frame_q.pop_back());
    end
    foreach (frame_q[i]) begin
      beat.data = frame_q[i];
      beat.last = (i == frame_q.size() - 1);
      pending_beats.push_back(beat);
    end
    beats_queued += frame_q.size();
  endtask

  task automatic queue_random_traffic(input int beats);
    int sel;
    int n;
    int junk;
    int keep;
    logic [7:0] kind;
    logic [7:0] d2;
    logic [7:0] sum_err;
    int stop_at;
    stop_at = beats_queued + beats;
    while (beats_queued < stop_at) begin
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 39) == 0)
        n = ($urandom_range(0, 1) == 0) ? 255 : $urandom_range(9, 254);
      else n = $urandom_range(0, 8);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: kind = TYPE_PHOTO;
        4, 5, 6, 7: kind = TYPE_HS;
        default: kind = 8'($urandom_range(0, 255));
      endcase
      d2 = ($urandom_range(0, 1) == 0) ? ready_code_model : 8'($urandom_range(0, 255));
      sum_err = (sel < 10) ? 8'($urandom_range(1, 255)) : 8'd0;
      junk = $urandom_range(0, 3);
      if (sel >= 10 && sel < 20) keep = $urandom_range(1, junk + n + 4);
      else if (sel >= 20 && sel < 27) begin
        junk = $urandom_range(1, 8);
        keep = junk;
      end else keep = -1;
      queue_buffer(n, kind, d2, sum_err, junk, keep,
                   ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
    end
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_tvalid || expected_status_q.size() != 0)
      @(posedge clk);
  endtask

  // Waits until every queued byte has been accepted and every expected status checked,
  // and lets the clock run on before the register changes.
  task automatic write_ready_code(input logic [7:0] code);
    wait_drained();
    repeat (6) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= code;
    ready_code_model = code;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    rx_beat_t beat;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_frame_byte(in_tdata, in_tlast);
        beats_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          beat = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= beat.data;
          in_tlast <= beat.last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    status_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        statuses_checked++;
        if (out_tdata[2:0] <= 3'd6) status_count[out_tdata[2:0]]++;
        if (expected_status_q.size() == 0) begin
          $display("%0t: status beat with none expected, expected none, actual %0d",
                   $time, out_tdata);
          error_count++;
        end else begin
          want = expected_status_q.pop_front();
          if (out_tdata !== {5'b00000, want}) begin
            $display("%0t: frame_status mismatch, expected %0d, actual %0d",
                     $time, want, out_tdata);
            error_count++;
          end
        end
      end
      cycle_count++;
      case ((cycle_count / 300) % 4)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 9) < 7);
        2: out_tready <= (cycle_count % 5 != 0);
        default: out_tready <= cycle_count[4];
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_ready_code(8'h5A);
    queue_buffer(3, TYPE_PHOTO, 8'h00, 8'h00, 0, -1, 0);
    queue_buffer(4, TYPE_HS, 8'h5A, 8'h00, 0, -1, 0);
    queue_buffer(4, TYPE_HS, 8'hA5, 8'h00, 0, -1, 0);
    queue_buffer(2, 8'h00, 8'h00, 8'h00, 0, -1, 0);
    queue_buffer(3, TYPE_PHOTO, 8'h00, 8'h80, 0, -1, 0);
    queue_buffer(6, TYPE_HS, 8'h00, 8'h00, 0, 5, 0);
    queue_buffer(2, TYPE_PHOTO, 8'h00, 8'h00, 0, 3, 0);
    lead_bytes = '{8'h00, 8'hFF, HDR_0, HDR_1, 8'h00};
    queue_buffer(2, TYPE_PHOTO, 8'h00, 8'h00, 0, 5, 0);
    queue_buffer(0, TYPE_HS, 8'h00, 8'h00, 0, -1, 0);
    queue_buffer(1, TYPE_PHOTO, 8'h00, 8'h00, 0, -1, 0);
    lead_bytes = '{HDR_0, HDR_1, HDR_0};
    queue_buffer(2, TYPE_PHOTO, 8'h00, 8'h00, 0, -1, 0);
    lead_bytes = '{8'h00, 8'h00, HDR_0, HDR_0};
    queue_buffer(3, TYPE_HS, 8'h5A, 8'h00, 0, -1, 3);

    write_ready_code(8'hFF);
    queue_random_traffic(240);
    write_ready_code(8'h00);
    queue_random_traffic(240);
    write_ready_code(8'($urandom_range(0, 255)));
    queue_random_traffic(240);
    write_ready_code(8'($urandom_range(0, 255)));
    queue_random_traffic(240);

    wait_drained();
    repeat (10) @(posedge clk);
    $write("Sent %0d byte beats and checked %0d status beats ",
           beats_accepted, statuses_checked);
    $display("under ready codes 0x5A, 0xFF, 0x00 and two random ones.");
    $write("Statuses: photo %0d, ready %0d, not ready %0d, ",
           status_count[0], status_count[1], status_count[2]);
    $display("no header %0d, truncated %0d, checksum %0d, invalid %0d.",
             status_count[3], status_count[4], status_count[5], status_count[6]);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/ufc_pkg.sv
rtl/core/ufc_parser.sv
rtl/core/ufc_out_reg.sv
rtl/core/uart_frame_checker.sv
sim/uart_frame_checker_tb.sv
